// File: rtl/ssr_pkg.sv
// Shared constants, register codes and types for the stream search and replace block.
package ssr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PatMaxDef = 8;   // default window depth
  localparam int unsigned RepMax    = 8;   // longest replacement text
  localparam int unsigned ResN      = 8;   // most results one item can produce
  localparam int unsigned PendN     = ResN + 1;
  localparam int unsigned CntW      = 4;
  localparam int unsigned LenW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatBytes = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatLen   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepBytes = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRepLen   = 2'd3;

  // Results of one item, handed from the window logic to the output chain
  typedef struct packed {
    logic [ResN-1:0][ByteW-1:0] data;
    logic [ResN-1:0]            last;
    logic [CntW-1:0]            cnt;
  } res_t;

endpackage

// File: rtl/ssr_if.sv
// Stream interfaces for text input and edited text output.
interface ssr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssr_pkg::ByteW-1:0] text_byte;
  logic                      is_end;

  modport source (output valid, text_byte, is_end, input ready);
  modport sink (input valid, text_byte, is_end, output ready);
endinterface

interface ssr_out_if;
  logic                      valid;
  logic                      ready;
  logic [ssr_pkg::ByteW-1:0] out_byte;
  logic                      last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// File: rtl/ssr_cell.sv
// One window cell: holds a text byte and compares it against every pattern byte.
module ssr_cell #(
  parameter int unsigned PAT_N = ssr_pkg::PatMaxDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [ssr_pkg::ByteW-1:0]            text_byte_i,
  input  logic                                 take_i,
  input  logic                                 load_i,
  input  logic [ssr_pkg::ByteW-1:0]            next_i,
  input  logic [PAT_N-1:0][ssr_pkg::ByteW-1:0] pat_i,
  output logic [ssr_pkg::ByteW-1:0]            cur_o,
  output logic [PAT_N-1:0]                     eq_o
);

  logic [ssr_pkg::ByteW-1:0] byte_q, byte_d;

  // the incoming byte lands in this cell when it is the append slot
  assign cur_o  = take_i ? text_byte_i : byte_q;
  assign byte_d = load_i ? next_i : byte_q;

  // compare against each pattern offset
  for (genvar d = 0; d < PAT_N; d++) begin : g_cmp
    assign eq_o[d] = (cur_o == pat_i[d]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

endmodule

// File: rtl/ssr_emit.sv
// Output chain: queued result bytes shift toward the output port one per transfer.
module ssr_emit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  ssr_pkg::res_t                res_i,
  output logic                         room_o,
  output logic [ssr_pkg::CntW-1:0]     cnt_o,
  ssr_out_if.source                    edit_o
);

  logic [ssr_pkg::PendN-1:0][ssr_pkg::ByteW-1:0] data_q, data_d;
  logic [ssr_pkg::PendN-1:0]                     last_q, last_d;
  logic [ssr_pkg::CntW-1:0]                      cnt_q, cnt_d, cnt_a;
  logic                                          take;

  assign take            = edit_o.valid && edit_o.ready;
  assign edit_o.valid    = (cnt_q != '0);
  assign edit_o.out_byte = data_q[0];
  assign edit_o.last     = last_q[0];
  // a new item may come in while at most one result is still waiting
  assign room_o          = (cnt_q <= ssr_pkg::CntW'(1));
  assign cnt_o           = cnt_q;

  // shift on output transfer, then append new results behind what is left
  always_comb begin
    data_d = data_q;
    last_d = last_q;
    cnt_a  = cnt_q - ssr_pkg::CntW'(take);
    if (take) begin
      for (int p = 0; p < ssr_pkg::PendN - 1; p++) begin
        data_d[p] = data_q[p+1];
        last_d[p] = last_q[p+1];
      end
    end
    if (load_i) begin
      for (int p = 0; p < ssr_pkg::ResN; p++) begin
        if (cnt_a == '0) begin
          data_d[p] = res_i.data[p];
          last_d[p] = res_i.last[p];
        end else begin
          data_d[p+1] = res_i.data[p];
          last_d[p+1] = res_i.last[p];
        end
      end
    end
    cnt_d = cnt_a + (load_i ? res_i.cnt : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

endmodule

// File: rtl/stream_search_replace.sv
// Top level of the stream search and replace block.
// Replaces every leftmost, non-overlapping occurrence of the configured pattern in a byte
// stream with the replacement text; an end item flushes the held bytes and sends a zero byte
// marked last. The window cells are compared against all pattern offsets in the cycle a byte
// arrives, so an item is taken every cycle while at most one result waits in the output chain.
// An item that yields k results (k up to 8) holds the input until at most one of them is left
// waiting, while the output chain drains one byte per transfer; items yielding zero or one
// result flow at one per cycle while the output is not stalled. Configuration is to be written
// only while the block is idle; the user is bound by this, the block itself does not enforce it.
module stream_search_replace #(
  parameter int unsigned MAX_PATTERN = ssr_pkg::PatMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ssr_pkg::CfgDataW-1:0]   cfg_data_i,
  ssr_in_if.sink                         text_i,
  ssr_out_if.source                      edit_o
);

  localparam int unsigned Cap   = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
  localparam int unsigned FillW = $clog2(Cap + 1);

  // configuration registers
  logic [ssr_pkg::CfgDataW-1:0] pat_q, rep_q;
  logic [ssr_pkg::LenW-1:0]     pat_len_q, rep_len_q;

  logic [Cap-1:0][ssr_pkg::ByteW-1:0] pat;
  logic [Cap-1:0][ssr_pkg::ByteW-1:0] cur, nw;
  logic [Cap-1:0][Cap-1:0]            eq;
  logic [FillW-1:0]                   fill_q, fill_d, f0, f, plen, sel, amt;
  logic [ssr_pkg::LenW-1:0]           rlen;
  logic [Cap:0]                       ok;
  logic                               full, in_fire, room;
  logic [ssr_pkg::CntW-1:0]           emit_cnt;
  ssr_pkg::res_t                      res;

  assign in_fire      = text_i.valid && text_i.ready;
  assign text_i.ready = room;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= '0;
      pat_len_q <= ssr_pkg::LenW'(1);
      rep_q     <= '0;
      rep_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssr_pkg::CfgPatBytes: pat_q     <= cfg_data_i;
        ssr_pkg::CfgPatLen:   pat_len_q <= cfg_data_i[ssr_pkg::LenW-1:0];
        ssr_pkg::CfgRepBytes: rep_q     <= cfg_data_i;
        ssr_pkg::CfgRepLen:   rep_len_q <= cfg_data_i[ssr_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar d = 0; d < Cap; d++) begin : g_pat
    assign pat[d] = pat_q[ssr_pkg::ByteW*d +: ssr_pkg::ByteW];
  end

  // effective lengths and append slot
  always_comb begin
    if (pat_len_q == '0) begin
      plen = FillW'(1);
    end else if (int'(pat_len_q) > Cap) begin
      plen = FillW'(Cap);
    end else begin
      plen = FillW'(pat_len_q);
    end
    rlen = (int'(rep_len_q) > ssr_pkg::RepMax) ? ssr_pkg::LenW'(ssr_pkg::RepMax) : rep_len_q;
    f0   = (int'(fill_q) >= Cap) ? FillW'(Cap - 1) : fill_q;
    f    = f0 + FillW'(1);
  end

  // window cells
  for (genvar j = 0; j < Cap; j++) begin : g_cell
    ssr_cell #(
      .PAT_N (Cap)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .text_byte_i (text_i.text_byte),
      .take_i      (!text_i.is_end && (int'(f0) == j)),
      .load_i      (in_fire && !text_i.is_end),
      .next_i      (nw[j]),
      .pat_i       (pat),
      .cur_o       (cur[j]),
      .eq_o        (eq[j])
    );
  end

  // ok[s]: window with s bytes dropped still starts a (partial) match
  always_comb begin
    for (int s = 0; s <= Cap; s++) begin
      ok[s] = 1'b1;
      for (int j = 0; j < Cap; j++) begin
        if (j >= s && j < int'(f) && (j - s) < int'(plen)) begin
          ok[s] = ok[s] & eq[j][j-s];
        end
      end
    end
    full = (f >= plen) && ok[0];
    // smallest drop count that leaves a possible match start
    sel = FillW'(Cap);
    for (int s = Cap; s >= 0; s--) begin
      if (ok[s]) begin
        sel = FillW'(s);
      end
    end
    amt = full ? plen : sel;
  end

  // shift the window by the drop amount
  always_comb begin
    for (int j = 0; j < Cap; j++) begin
      nw[j] = '0;
      for (int k = 0; k < Cap - j; k++) begin
        if (int'(amt) == k) begin
          nw[j] = cur[j+k];
        end
      end
    end
  end

  // results of the accepted item
  always_comb begin
    res = '0;
    if (text_i.is_end) begin
      for (int k = 0; k < Cap; k++) begin
        if (k < int'(fill_q)) begin
          res.data[k] = cur[k];
        end
      end
      for (int k = 0; k < ssr_pkg::ResN; k++) begin
        if (k == int'(fill_q)) begin
          res.last[k] = 1'b1;
        end
      end
      res.cnt = ssr_pkg::CntW'(fill_q) + ssr_pkg::CntW'(1);
    end else if (full) begin
      for (int k = 0; k < ssr_pkg::RepMax; k++) begin
        res.data[k] = rep_q[ssr_pkg::ByteW*k +: ssr_pkg::ByteW];
      end
      res.cnt = ssr_pkg::CntW'(rlen);
    end else begin
      for (int k = 0; k < Cap; k++) begin
        res.data[k] = cur[k];
      end
      res.cnt = ssr_pkg::CntW'(sel);
    end
  end

  // window fill
  always_comb begin
    fill_d = fill_q;
    if (in_fire) begin
      fill_d = text_i.is_end ? '0 : (f - amt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // output chain
  ssr_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (in_fire),
    .res_i  (res),
    .room_o (room),
    .cnt_o  (emit_cnt),
    .edit_o (edit_o)
  );

  // the window never holds a full depth of bytes between items
  a_fill_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) < Cap)
    else $error("window fill reached its depth");

  // an end transfer empties the window
  a_end_flushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && text_i.is_end) |=> (fill_q == '0))
    else $error("window not empty after end transfer");

  // output chain never overflows
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(emit_cnt) <= ssr_pkg::PendN)
    else $error("output chain overflow");

endmodule

// File: bench/tb_stream_search_replace.sv
// Self-checking testbench for the stream search and replace block.
module tb_stream_search_replace;
  timeunit 1ns;
  timeprecision 1ps;

  import ssr_pkg::*;

  localparam int unsigned MaxPattern  = PatMaxDef;
  localparam int unsigned PatCap      = (MaxPattern < 8) ? MaxPattern : 8;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned LongHold    = 120;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             is_end;
  } text_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } edit_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ssr_in_if  text_if ();
  ssr_out_if edit_if ();

  stream_search_replace #(
    .MAX_PATTERN(MaxPattern)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .text_i    (text_if),
    .edit_o    (edit_if)
  );

  // Pending text items and edited bytes still owed by the block
  text_item_t text_q[$];
  edit_byte_t edit_q[$];

  // Shadow copy of the registers and the match window
  logic [63:0]      pat_reg  = '0;
  logic [LenW-1:0]  pat_len  = LenW'(1);
  logic [63:0]      rep_reg  = '0;
  logic [LenW-1:0]  rep_len  = '0;
  logic [ByteW-1:0] shadow_win [0:MaxPattern-1];
  int unsigned      shadow_fill = 0;

  int unsigned mismatches    = 0;
  int unsigned hold_requests = 0;
  logic        quiet         = 1'b0;
  int unsigned cycles        = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_edit_byte(input logic [ByteW-1:0] b, input logic l);
    edit_byte_t e;
    e.out_byte = b;
    e.last     = l;
    edit_q.push_back(e);
  endfunction

  function automatic bit window_starts_with(input int unsigned n);
    for (int i = 0; i < n; i++)
      if (shadow_win[i] != pat_reg[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void window_drop(input int unsigned n);
    int unsigned cnt;
    cnt = (n > shadow_fill) ? shadow_fill : n;
    for (int i = 0; i + cnt < shadow_fill; i++) shadow_win[i] = shadow_win[i + cnt];
    shadow_fill -= cnt;
  endfunction

  // Edited bytes caused by one accepted text item
  function automatic void predict_edit(input logic [ByteW-1:0] tb, input logic is_end);
    int unsigned plen;
    int unsigned rlen;
    int unsigned n;
    plen = (pat_len == 0) ? 1 : int'(pat_len);
    if (plen > PatCap) plen = PatCap;

    // end of text: flush window as is, then terminator
    if (is_end) begin
      for (int i = 0; i < shadow_fill && i < MaxPattern; i++)
        queue_edit_byte(shadow_win[i], 1'b0);
      shadow_fill = 0;
      queue_edit_byte('0, 1'b1);
      return;
    end

    if (shadow_fill >= PatCap) shadow_fill = PatCap - 1;
    shadow_win[shadow_fill] = tb;
    shadow_fill++;

    // full match at the front: emit replacement only
    if (shadow_fill >= plen && window_starts_with(plen)) begin
      rlen = (rep_len > 8) ? 8 : int'(rep_len);
      for (int i = 0; i < rlen; i++) queue_edit_byte(rep_reg[8*i +: 8], 1'b0);
      window_drop(plen);
      return;
    end

    // pop bytes that can no longer start a match
    while (shadow_fill > 0) begin
      n = (shadow_fill < plen) ? shadow_fill : plen;
      if (window_starts_with(n)) break;
      queue_edit_byte(shadow_win[0], 1'b0);
      window_drop(1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: text source with random gaps
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_text
    text_item_t  nxt;
    int unsigned gap_left;
    if (!rst_ni) begin
      gap_left = 0;
      text_if.valid <= 1'b0;
    end else if (!text_if.valid || text_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        text_if.valid <= 1'b0;
      end else if (text_q.size() > 0) begin
        nxt = text_q.pop_front();
        text_if.valid     <= 1'b1;
        text_if.text_byte <= nxt.text_byte;
        text_if.is_end    <= nxt.is_end;
        if (!quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 12);
      end else begin
        text_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus requested long hold-offs
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : drive_ready
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_served;
    if (!rst_ni) begin
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      edit_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      edit_if.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LongHold;
      edit_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      edit_if.ready <= 1'b0;
    end else begin
      edit_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each text transfer, then check each edit transfer
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i) begin : watch_streams
    edit_byte_t want;
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) predict_edit(text_if.text_byte, text_if.is_end);
      if (edit_if.valid && edit_if.ready) begin
        if (edit_q.size() == 0) begin
          report_mismatch($sformatf("edit byte %02h last %0d with nothing pending",
                                    edit_if.out_byte, edit_if.last));
        end else begin
          want = edit_q.pop_front();
          if (edit_if.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte: expected %02h, got %02h",
                                      want.out_byte, edit_if.out_byte));
          if (edit_if.last !== want.last)
            report_mismatch($sformatf("last: expected %0d, got %0d (byte %02h)",
                                      want.last, edit_if.last, edit_if.out_byte));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("stream_search_replace regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_text(input logic [ByteW-1:0] b);
    text_item_t it;
    it.text_byte = b;
    it.is_end    = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic send_end();
    text_item_t it;
    it.text_byte = ByteW'($urandom_range(0, 255));
    it.is_end    = 1'b1;
    text_q.push_back(it);
  endtask

  // Wait until every item is sent and every edited byte has come back
  task automatic settle();
    while (text_q.size() != 0 || text_if.valid || edit_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgPatBytes: pat_reg = val;
      CfgPatLen:   pat_len = val[LenW-1:0];
      CfgRepBytes: rep_reg = val;
      CfgRepLen:   rep_len = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] pat, input int unsigned plen,
                             input logic [63:0] rep, input int unsigned rlen);
    settle();
    cfg_write(CfgPatBytes, pat);
    cfg_write(CfgPatLen, 64'(plen));
    cfg_write(CfgRepBytes, rep);
    cfg_write(CfgRepLen, 64'(rlen));
    cfg_we_i <= 1'b0;
  endtask

  // One text drawn mostly from the pattern's own alphabet so matches are frequent
  task automatic random_phase(input int unsigned n_items, input int unsigned plen,
                              input int unsigned rlen);
    logic [ByteW-1:0] alpha [0:2];
    logic [63:0]      pat;
    int unsigned      sent;
    int unsigned      r;
    int unsigned      k;
    for (int i = 0; i < 3; i++) alpha[i] = ByteW'($urandom_range(0, 255));
    pat = {$urandom, $urandom};
    for (int i = 0; i < plen; i++) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
    load_config(pat, plen, {$urandom, $urandom}, rlen);

    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        for (int i = 0; i < plen; i++) send_text(pat[8*i +: 8]);
        sent += plen;
      end else if (r < 55 && plen > 1) begin
        // partial pattern that has to be released again
        k = $urandom_range(1, plen - 1);
        for (int i = 0; i < k; i++) send_text(pat[8*i +: 8]);
        sent += k;
      end else if (r < 85) begin
        send_text(alpha[$urandom_range(0, 2)]);
        sent++;
      end else if (r < 94) begin
        send_text(ByteW'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_end();
        sent++;
      end
    end
    // sometimes leave the window loaded across the next register change
    if ($urandom_range(0, 3) != 0) send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgPatBytes;
    cfg_data_i        = '0;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    text_if.is_end    = 1'b0;
    edit_if.ready     = 1'b0;
    for (int i = 0; i < MaxPattern; i++) shadow_win[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: single zero-byte pattern deleted, extremes of text byte
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h00);
    send_end();

    // overlapping candidates and a full 8-byte replacement holding a zero byte
    load_config(64'h0000_0000_0000_6261, 2, 64'h00FF_1122_3344_5580, 8);
    send_text(8'h61);
    send_text(8'h61);
    send_text(8'h62);
    send_text(8'h61);
    send_text(8'h62);
    send_end();

    // longest pattern; end flushes seven held bytes plus terminator
    load_config(64'h6867_6665_6463_6261, 8, 64'h0000_0000_0000_00FF, 1);
    for (int i = 0; i < 7; i++) send_text(8'h61 + 8'(i));
    send_end();

    // pattern shortened while the window holds a match at its front
    for (int i = 0; i < 7; i++) send_text(8'h61 + 8'(i));
    load_config(64'h6867_6665_6463_6261, 3, 64'h0000_0000_0000_5958, 2);
    send_text(8'h7A);
    send_end();

    // random texts, extremes of both lengths first
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 6) quiet <= 1'b1;
      random_phase(22, (ph == 0) ? 1 : (ph == 1) ? 8 : $urandom_range(1, 8),
                   (ph == 0) ? 8 : (ph == 1) ? 0 : $urandom_range(0, 8));
      // receiver holds off while the sender keeps offering
      if (ph == 2) hold_requests <= hold_requests + 1;
    end

    settle();
    if (mismatches == 0) begin
      $display("stream_search_replace regression: pass");
    end else begin
      $display("stream_search_replace regression: fail");
    end
    $finish;
  end

endmodule
